@@ src/owbm_pkg.sv @@
package owbm_pkg;

    localparam int CFG_BITS   = 10;
    localparam int CFG_COUNT  = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int BIT_IDX_W  = 3;

    // command kinds carried in an input item
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_RESET = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;
    localparam logic [1:0] KIND_READ  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE_WAIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_TAIL    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_LOW     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_HOLD    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_RECOVER = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_LOW      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_SAMPLE   = 3'd7;

    // register reset values, in microseconds
    localparam logic [CFG_BITS-1:0] RST_RESET_LOW     = 10'd480;
    localparam logic [CFG_BITS-1:0] RST_PRESENCE_WAIT = 10'd70;
    localparam logic [CFG_BITS-1:0] RST_RESET_TAIL    = 10'd410;
    localparam logic [CFG_BITS-1:0] RST_WRITE_LOW     = 10'd6;
    localparam logic [CFG_BITS-1:0] RST_WRITE_HOLD    = 10'd54;
    localparam logic [CFG_BITS-1:0] RST_WRITE_RECOVER = 10'd10;
    localparam logic [CFG_BITS-1:0] RST_READ_LOW      = 10'd5;
    localparam logic [CFG_BITS-1:0] RST_READ_SAMPLE   = 10'd10;

    // fixed wait after a read sample
    localparam logic [CFG_BITS-1:0] READ_TAIL_US = 10'd55;
    localparam logic [BIT_IDX_W-1:0] LAST_BIT    = 3'd7;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic       line_level;
    } in_item_t;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic       presence;
        logic [7:0] read_byte;
        logic       rejected;
    } out_item_t;

endpackage

@@ src/onewire_bus_master_core.sv @@
// 1-Wire bus master core.
// The result item for an accepted input item is in the output register in the next cycle.
// Throughput: one item per cycle; the output register lets a new item in while a
// result is still being taken, so only a stalled result with a full register stops input.
// Reset (aresetn low, synchronous): phase idle, line released, flags and read byte
// cleared, timing registers back to their standard values, output register empty.
module onewire_bus_master_core #(
    parameter int TIMER_BITS = 10
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input items: ticks and commands
    input  logic                                s_valid,
    output logic                                s_ready,
    input  owbm_pkg::in_item_t                  s_data,
    // result items, one per input item
    output logic                                m_valid,
    input  logic                                m_ready,
    output owbm_pkg::out_item_t                 m_data,
    // timing register writes
    input  logic                                cfg_we,
    input  logic [owbm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [owbm_pkg::CFG_BITS-1:0]       cfg_data
);

    // phase codes
    localparam logic [3:0] PH_IDLE     = 4'd0;
    localparam logic [3:0] PH_RST_LOW  = 4'd1;
    localparam logic [3:0] PH_RST_WAIT = 4'd2;
    localparam logic [3:0] PH_RST_TAIL = 4'd3;
    localparam logic [3:0] PH_WR_LOW   = 4'd4;
    localparam logic [3:0] PH_WR_HOLD  = 4'd5;
    localparam logic [3:0] PH_WR_REC   = 4'd6;
    localparam logic [3:0] PH_RD_LOW   = 4'd7;
    localparam logic [3:0] PH_RD_WAIT  = 4'd8;
    localparam logic [3:0] PH_RD_TAIL  = 4'd9;

    // timing registers
    logic [owbm_pkg::CFG_BITS-1:0] cfg_reg [owbm_pkg::CFG_COUNT];

    // bus state
    logic [3:0]                       phase_reg,    phase_next;
    logic [TIMER_BITS-1:0]            timer_reg,    timer_next;
    logic [owbm_pkg::BIT_IDX_W-1:0]   bit_idx_reg,  bit_idx_next;
    logic [7:0]                       shift_reg,    shift_next;
    logic                             drive_reg,    drive_next;
    logic                             presence_reg, presence_next;
    logic [7:0]                       rd_byte_reg,  rd_byte_next;

    // output register
    logic                             m_valid_reg;
    owbm_pkg::out_item_t              m_data_reg, m_data_next;

    logic accept;
    logic expired;
    logic done_w;
    logic rejected_w;
    logic last_bit;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // a loaded zero counts like one: the phase ends on the first tick
    assign expired  = (timer_reg <= TIMER_BITS'(1));
    assign last_bit = (bit_idx_reg >= owbm_pkg::LAST_BIT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg[owbm_pkg::CFG_RESET_LOW]     <= owbm_pkg::RST_RESET_LOW;
            cfg_reg[owbm_pkg::CFG_PRESENCE_WAIT] <= owbm_pkg::RST_PRESENCE_WAIT;
            cfg_reg[owbm_pkg::CFG_RESET_TAIL]    <= owbm_pkg::RST_RESET_TAIL;
            cfg_reg[owbm_pkg::CFG_WRITE_LOW]     <= owbm_pkg::RST_WRITE_LOW;
            cfg_reg[owbm_pkg::CFG_WRITE_HOLD]    <= owbm_pkg::RST_WRITE_HOLD;
            cfg_reg[owbm_pkg::CFG_WRITE_RECOVER] <= owbm_pkg::RST_WRITE_RECOVER;
            cfg_reg[owbm_pkg::CFG_READ_LOW]      <= owbm_pkg::RST_READ_LOW;
            cfg_reg[owbm_pkg::CFG_READ_SAMPLE]   <= owbm_pkg::RST_READ_SAMPLE;
        end else if (cfg_we) begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    // next bus state for the item at the input
    always_comb begin
        phase_next    = phase_reg;
        timer_next    = timer_reg;
        bit_idx_next  = bit_idx_reg;
        shift_next    = shift_reg;
        drive_next    = drive_reg;
        presence_next = presence_reg;
        rd_byte_next  = rd_byte_reg;
        done_w        = 1'b0;
        rejected_w    = 1'b0;

        if (s_data.kind != owbm_pkg::KIND_TICK) begin
            if (phase_reg != PH_IDLE) begin
                // command while busy: flag it, otherwise no effect
                rejected_w = 1'b1;
            end else begin
                bit_idx_next = '0;
                drive_next   = 1'b1;
                case (s_data.kind)
                    owbm_pkg::KIND_RESET: begin
                        phase_next = PH_RST_LOW;
                        timer_next = TIMER_BITS'(cfg_reg[owbm_pkg::CFG_RESET_LOW]);
                    end
                    owbm_pkg::KIND_WRITE: begin
                        shift_next = s_data.data_byte;
                        phase_next = PH_WR_LOW;
                        timer_next = TIMER_BITS'(cfg_reg[owbm_pkg::CFG_WRITE_LOW]);
                    end
                    default: begin
                        shift_next = '0;
                        phase_next = PH_RD_LOW;
                        timer_next = TIMER_BITS'(cfg_reg[owbm_pkg::CFG_READ_LOW]);
                    end
                endcase
            end
        end else if (phase_reg != PH_IDLE) begin
            timer_next = expired ? '0 : timer_reg - TIMER_BITS'(1);
            if (expired) begin
                case (phase_reg)
                    PH_RST_LOW: begin
                        phase_next = PH_RST_WAIT;
                        timer_next = TIMER_BITS'(cfg_reg[owbm_pkg::CFG_PRESENCE_WAIT]);
                        drive_next = 1'b0;
                    end
                    PH_RST_WAIT: begin
                        // a device answers by holding the line low
                        presence_next = !s_data.line_level;
                        phase_next    = PH_RST_TAIL;
                        timer_next    = TIMER_BITS'(cfg_reg[owbm_pkg::CFG_RESET_TAIL]);
                        drive_next    = 1'b0;
                    end
                    PH_RST_TAIL: begin
                        phase_next = PH_IDLE;
                        timer_next = '0;
                        drive_next = 1'b0;
                        done_w     = 1'b1;
                    end
                    PH_WR_LOW: begin
                        // zero bit keeps the line low for the hold time
                        phase_next = PH_WR_HOLD;
                        timer_next = TIMER_BITS'(cfg_reg[owbm_pkg::CFG_WRITE_HOLD]);
                        drive_next = !shift_reg[0];
                    end
                    PH_WR_HOLD: begin
                        phase_next = PH_WR_REC;
                        timer_next = TIMER_BITS'(cfg_reg[owbm_pkg::CFG_WRITE_RECOVER]);
                        drive_next = 1'b0;
                    end
                    PH_WR_REC: begin
                        if (last_bit) begin
                            phase_next = PH_IDLE;
                            timer_next = '0;
                            drive_next = 1'b0;
                            done_w     = 1'b1;
                        end else begin
                            bit_idx_next = bit_idx_reg + 1'b1;
                            shift_next   = {1'b0, shift_reg[7:1]};
                            phase_next   = PH_WR_LOW;
                            timer_next   = TIMER_BITS'(cfg_reg[owbm_pkg::CFG_WRITE_LOW]);
                            drive_next   = 1'b1;
                        end
                    end
                    PH_RD_LOW: begin
                        phase_next = PH_RD_WAIT;
                        timer_next = TIMER_BITS'(cfg_reg[owbm_pkg::CFG_READ_SAMPLE]);
                        drive_next = 1'b0;
                    end
                    PH_RD_WAIT: begin
                        // LSB first: each sample enters at the top
                        shift_next = {s_data.line_level, shift_reg[7:1]};
                        phase_next = PH_RD_TAIL;
                        timer_next = TIMER_BITS'(owbm_pkg::READ_TAIL_US);
                        drive_next = 1'b0;
                    end
                    PH_RD_TAIL: begin
                        if (last_bit) begin
                            rd_byte_next = shift_reg;
                            phase_next   = PH_IDLE;
                            timer_next   = '0;
                            drive_next   = 1'b0;
                            done_w       = 1'b1;
                        end else begin
                            bit_idx_next = bit_idx_reg + 1'b1;
                            phase_next   = PH_RD_LOW;
                            timer_next   = TIMER_BITS'(cfg_reg[owbm_pkg::CFG_READ_LOW]);
                            drive_next   = 1'b1;
                        end
                    end
                    default: begin
                        phase_next = PH_IDLE;
                        timer_next = '0;
                        drive_next = 1'b0;
                    end
                endcase
            end
        end

        m_data_next.drive_low = drive_next;
        m_data_next.busy_res  = (phase_next != PH_IDLE);
        m_data_next.done_res  = done_w;
        m_data_next.presence  = presence_next;
        m_data_next.read_byte = rd_byte_next;
        m_data_next.rejected  = rejected_w;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            timer_reg    <= '0;
            bit_idx_reg  <= '0;
            shift_reg    <= '0;
            drive_reg    <= 1'b0;
            presence_reg <= 1'b0;
            rd_byte_reg  <= '0;
        end else if (accept) begin
            phase_reg    <= phase_next;
            timer_reg    <= timer_next;
            bit_idx_reg  <= bit_idx_next;
            shift_reg    <= shift_next;
            drive_reg    <= drive_next;
            presence_reg <= presence_next;
            rd_byte_reg  <= rd_byte_next;
        end
    end

    // result register: loads on every accepted item, empties when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

@@ src/owbm_checker.sv @@
module owbm_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input owbm_pkg::in_item_t             s_data,
    input logic                           m_valid,
    input logic                           m_ready,
    input owbm_pkg::out_item_t            m_data
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // a command can only be rejected while another one runs
    a_reject_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.rejected |-> m_data.busy_res && !m_data.done_res)
        else $error("rejected item without a command in progress");

    // completion leaves the bus idle and released
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.done_res |-> !m_data.busy_res && !m_data.drive_low)
        else $error("done reported while still busy or driving");

    // idle master never pulls the line
    a_idle_release: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.busy_res |-> !m_data.drive_low)
        else $error("line driven low while idle");

    // a tick item accepted while idle and taken at once leaves the block idle
    a_tick_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_data.busy_res && s_valid && s_ready
            && (s_data.kind == owbm_pkg::KIND_TICK)
        |=> m_valid && !m_data.busy_res && !m_data.done_res)
        else $error("tick started a command");

endmodule

bind onewire_bus_master_core owbm_checker u_owbm_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_data    (s_data),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_data    (m_data)
);

@@ sim/tb.sv @@
`timescale 1ns / 100ps

module tb;

    localparam int STALL_LIMIT  = 3000;   // cycles with no handshake before giving up
    localparam int RANDOM_ITEMS = 200;    // busy-time items in the random part
    localparam int MAX_PRINTS   = 40;

    // line level patterns for the bus while a command runs
    localparam int LVL_LOW  = 0;
    localparam int LVL_HIGH = 1;
    localparam int LVL_RAND = 2;

    typedef enum logic [3:0] {
        PH_IDLE, PH_RST_LOW, PH_RST_WAIT, PH_RST_TAIL, PH_WR_LOW, PH_WR_HOLD,
        PH_WR_REC, PH_RD_LOW, PH_RD_WAIT, PH_RD_TAIL
    } bus_phase_e;

    logic                           aclk;
    logic                           aresetn;
    logic                           s_valid;
    logic                           s_ready;
    owbm_pkg::in_item_t             s_data;
    logic                           m_valid;
    logic                           m_ready;
    owbm_pkg::out_item_t            m_data;
    logic                           cfg_we;
    logic [owbm_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [owbm_pkg::CFG_BITS-1:0]  cfg_data;

    // model of the sequencer: timing registers and bus state
    logic [owbm_pkg::CFG_BITS-1:0]  timing_us [owbm_pkg::CFG_COUNT];
    bus_phase_e                     bus_phase;
    logic [owbm_pkg::CFG_BITS-1:0]  slot_timer;
    logic [owbm_pkg::BIT_IDX_W-1:0] bit_pos;
    logic [7:0]                     shift_reg;
    logic                           pull_low;
    logic                           device_seen;
    logic [7:0]                     last_read;

    owbm_pkg::out_item_t expected_status_q[$];
    owbm_pkg::out_item_t want;

    bit idle_on;
    int err_count;
    int items_sent;
    int work_items;     // items that were not idle ticks
    int status_seen;
    int cmds_done;
    int cmds_rejected;
    int quiet_cycles;

    onewire_bus_master_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // ---------------------------------------------------------------------------
    // Sequencer model
    // ---------------------------------------------------------------------------
    function automatic void enter_phase(bus_phase_e p, logic [owbm_pkg::CFG_BITS-1:0] ticks,
                                        logic low);
        bus_phase  = p;
        slot_timer = ticks;
        pull_low   = low;
    endfunction

    // Advance the model by one accepted item; returns the status it should produce.
    function automatic owbm_pkg::out_item_t bus_master_next(owbm_pkg::in_item_t it);
        owbm_pkg::out_item_t r;
        logic                expired;
        r = '0;
        if (it.kind != owbm_pkg::KIND_TICK || bus_phase != PH_IDLE) begin
            work_items++;
        end
        if (it.kind != owbm_pkg::KIND_TICK) begin
            if (bus_phase != PH_IDLE) begin
                // command while busy: flagged, otherwise dropped (not a tick either)
                r.rejected = 1'b1;
                cmds_rejected++;
            end else begin
                bit_pos = '0;
                case (it.kind)
                    owbm_pkg::KIND_RESET: begin
                        enter_phase(PH_RST_LOW, timing_us[owbm_pkg::CFG_RESET_LOW], 1'b1);
                    end
                    owbm_pkg::KIND_WRITE: begin
                        shift_reg = it.data_byte;
                        enter_phase(PH_WR_LOW, timing_us[owbm_pkg::CFG_WRITE_LOW], 1'b1);
                    end
                    default: begin
                        shift_reg = '0;
                        enter_phase(PH_RD_LOW, timing_us[owbm_pkg::CFG_READ_LOW], 1'b1);
                    end
                endcase
            end
        end else if (bus_phase != PH_IDLE) begin
            // a loaded zero expires on the first tick, same as one
            expired    = (slot_timer <= 1);
            slot_timer = expired ? '0 : slot_timer - 1'b1;
            if (expired) begin
                case (bus_phase)
                    PH_RST_LOW: begin
                        enter_phase(PH_RST_WAIT, timing_us[owbm_pkg::CFG_PRESENCE_WAIT],
                                    1'b0);
                    end
                    PH_RST_WAIT: begin
                        // a device answers by holding the line low
                        device_seen = ~it.line_level;
                        enter_phase(PH_RST_TAIL, timing_us[owbm_pkg::CFG_RESET_TAIL], 1'b0);
                    end
                    PH_RST_TAIL: begin
                        enter_phase(PH_IDLE, '0, 1'b0);
                        r.done_res = 1'b1;
                    end
                    PH_WR_LOW: begin
                        // one bit releases early, zero bit stays low for the slot
                        enter_phase(PH_WR_HOLD, timing_us[owbm_pkg::CFG_WRITE_HOLD],
                                    ~shift_reg[0]);
                    end
                    PH_WR_HOLD: begin
                        enter_phase(PH_WR_REC, timing_us[owbm_pkg::CFG_WRITE_RECOVER], 1'b0);
                    end
                    PH_WR_REC: begin
                        if (bit_pos >= owbm_pkg::LAST_BIT) begin
                            enter_phase(PH_IDLE, '0, 1'b0);
                            r.done_res = 1'b1;
                        end else begin
                            bit_pos   = bit_pos + 1'b1;
                            shift_reg = shift_reg >> 1;
                            enter_phase(PH_WR_LOW, timing_us[owbm_pkg::CFG_WRITE_LOW], 1'b1);
                        end
                    end
                    PH_RD_LOW: begin
                        enter_phase(PH_RD_WAIT, timing_us[owbm_pkg::CFG_READ_SAMPLE], 1'b0);
                    end
                    PH_RD_WAIT: begin
                        // LSB first: new bit enters at the top
                        shift_reg = {it.line_level, shift_reg[7:1]};
                        enter_phase(PH_RD_TAIL, owbm_pkg::READ_TAIL_US, 1'b0);
                    end
                    PH_RD_TAIL: begin
                        if (bit_pos >= owbm_pkg::LAST_BIT) begin
                            last_read = shift_reg;
                            enter_phase(PH_IDLE, '0, 1'b0);
                            r.done_res = 1'b1;
                        end else begin
                            bit_pos = bit_pos + 1'b1;
                            enter_phase(PH_RD_LOW, timing_us[owbm_pkg::CFG_READ_LOW], 1'b1);
                        end
                    end
                    default: begin
                        enter_phase(PH_IDLE, '0, 1'b0);
                    end
                endcase
                if (r.done_res) begin
                    cmds_done++;
                end
            end
        end
        r.drive_low = pull_low;
        r.busy_res  = (bus_phase != PH_IDLE);
        r.presence  = device_seen;
        r.read_byte = last_read;
        return r;
    endfunction

    // ---------------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------------

    // Mostly no gap, some short, a few long.
    function automatic int idle_gap();
        int r;
        if (!idle_on) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        if (r < 98) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Slot times for the random part: short mostly, zero now and then.
    function automatic logic [owbm_pkg::CFG_BITS-1:0] pick_slot_time();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) begin
            return '0;
        end
        if (r < 75) begin
            return owbm_pkg::CFG_BITS'($urandom_range(1, 2));
        end
        if (r < 95) begin
            return owbm_pkg::CFG_BITS'($urandom_range(3, 8));
        end
        return owbm_pkg::CFG_BITS'($urandom_range(9, 16));
    endfunction

    task automatic report_mismatch(string what, int got, int exp_val);
        if (err_count < MAX_PRINTS) begin
            $display("%0t MISMATCH status #%0d %s: got 0x%0h, expected 0x%0h",
                     $realtime, status_seen, what, got, exp_val);
        end
        err_count++;
    endtask

    // Present one item and hold it until taken. Valid stays up if the next call
    // sends without a gap.
    task automatic send_item(logic [1:0] kind, logic [7:0] data_val, logic level);
        owbm_pkg::in_item_t it;
        int                 gap;
        it.kind       = kind;
        it.data_byte  = data_val;
        it.line_level = level;
        gap = idle_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_status_q.push_back(bus_master_next(it));
        items_sent++;
    endtask

    // Tick until the running command finishes.
    task automatic run_to_idle(int level_mode);
        logic lvl;
        while (bus_phase != PH_IDLE) begin
            lvl = (level_mode == LVL_RAND) ? logic'($urandom_range(0, 1))
                                           : (level_mode == LVL_HIGH);
            send_item(owbm_pkg::KIND_TICK, 8'($urandom), lvl);
        end
    endtask

    task automatic run_command(logic [1:0] kind, logic [7:0] data_val, int level_mode);
        send_item(kind, data_val, 1'($urandom));
        run_to_idle(level_mode);
    endtask

    // Stop sending and let every outstanding status drain, plus the pipeline delay.
    task automatic settle();
        s_valid <= 1'b0;
        while (expected_status_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(logic [owbm_pkg::CFG_IDX_W-1:0] idx,
                             logic [owbm_pkg::CFG_BITS-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        timing_us[idx] = val;
        @(posedge aclk);
    endtask

    // Only called with the sequencer idle.
    task automatic set_timing(logic [owbm_pkg::CFG_BITS-1:0] rst_low,
                              logic [owbm_pkg::CFG_BITS-1:0] pres_wait,
                              logic [owbm_pkg::CFG_BITS-1:0] rst_tail,
                              logic [owbm_pkg::CFG_BITS-1:0] wr_low,
                              logic [owbm_pkg::CFG_BITS-1:0] wr_hold,
                              logic [owbm_pkg::CFG_BITS-1:0] wr_rec,
                              logic [owbm_pkg::CFG_BITS-1:0] rd_low,
                              logic [owbm_pkg::CFG_BITS-1:0] rd_sample);
        settle();
        write_reg(owbm_pkg::CFG_RESET_LOW, rst_low);
        write_reg(owbm_pkg::CFG_PRESENCE_WAIT, pres_wait);
        write_reg(owbm_pkg::CFG_RESET_TAIL, rst_tail);
        write_reg(owbm_pkg::CFG_WRITE_LOW, wr_low);
        write_reg(owbm_pkg::CFG_WRITE_HOLD, wr_hold);
        write_reg(owbm_pkg::CFG_WRITE_RECOVER, wr_rec);
        write_reg(owbm_pkg::CFG_READ_LOW, rd_low);
        write_reg(owbm_pkg::CFG_READ_SAMPLE, rd_sample);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // ---------------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------------

    // Power-on timing: idle tick ignored, then a full read with the standard slots.
    task automatic test_default_timing();
        send_item(owbm_pkg::KIND_TICK, 8'hFF, 1'b0);
        run_command(owbm_pkg::KIND_READ, 8'h00, LVL_RAND);
    endtask

    // Shortest legal slots: presence both ways, all-zero/all-one/mixed write bytes.
    task automatic test_min_timing();
        set_timing(1, 1, 1, 1, 1, 1, 1, 1);
        run_command(owbm_pkg::KIND_RESET, 8'h00, LVL_LOW);
        run_command(owbm_pkg::KIND_RESET, 8'h00, LVL_HIGH);
        run_command(owbm_pkg::KIND_WRITE, 8'h00, LVL_RAND);
        run_command(owbm_pkg::KIND_WRITE, 8'hFF, LVL_RAND);
        run_command(owbm_pkg::KIND_WRITE, 8'hA5, LVL_RAND);
    endtask

    // Zero in every register must act like one tick.
    task automatic test_zero_timing();
        set_timing(0, 0, 0, 0, 0, 0, 0, 0);
        run_command(owbm_pkg::KIND_RESET, 8'h00, LVL_RAND);
        run_command(owbm_pkg::KIND_WRITE, 8'h5A, LVL_RAND);
    endtask

    // Commands while busy are flagged and dropped; a new one right after done is taken.
    task automatic test_busy_reject();
        int n;
        n = 0;
        set_timing(2, 1, 2, 1, 2, 1, 2, 1);
        send_item(owbm_pkg::KIND_WRITE, 8'hC3, 1'b1);
        send_item(owbm_pkg::KIND_RESET, 8'h00, 1'b0);
        send_item(owbm_pkg::KIND_READ, 8'hFF, 1'b1);
        send_item(owbm_pkg::KIND_WRITE, 8'h3C, 1'b0);
        while (bus_phase != PH_IDLE) begin
            n++;
            if (n % 5 == 0) begin
                send_item(2'($urandom_range(owbm_pkg::KIND_RESET, owbm_pkg::KIND_READ)),
                          8'($urandom), 1'($urandom));
            end else begin
                send_item(owbm_pkg::KIND_TICK, 8'($urandom), 1'($urandom));
            end
        end
        run_command(owbm_pkg::KIND_RESET, 8'h00, LVL_RAND);
    endtask

    // Random timing sets, whole commands with random content, stray commands
    // dropped in while busy, occasional idle ticks.
    task automatic test_random();
        int         start_items;
        int         r;
        logic [1:0] kind;
        start_items = work_items;
        while (work_items - start_items < RANDOM_ITEMS) begin
            idle_on = ($urandom_range(0, 3) != 0);
            set_timing(pick_slot_time(), pick_slot_time(), pick_slot_time(),
                       pick_slot_time(), pick_slot_time(), pick_slot_time(),
                       pick_slot_time(), pick_slot_time());
            repeat (3) begin
                if ($urandom_range(0, 9) == 0) begin
                    repeat ($urandom_range(1, 3)) begin
                        send_item(owbm_pkg::KIND_TICK, 8'($urandom), 1'($urandom));
                    end
                end
                // reads cost at least 57 ticks per bit; the directed part covers them
                r = $urandom_range(0, 99);
                kind = (r < 50) ? owbm_pkg::KIND_RESET : owbm_pkg::KIND_WRITE;
                send_item(kind, 8'($urandom), 1'($urandom));
                while (bus_phase != PH_IDLE) begin
                    if ($urandom_range(0, 11) == 0) begin
                        send_item(2'($urandom_range(owbm_pkg::KIND_RESET,
                                                    owbm_pkg::KIND_READ)),
                                  8'($urandom), 1'($urandom));
                    end else begin
                        send_item(owbm_pkg::KIND_TICK, 8'($urandom), 1'($urandom));
                    end
                end
            end
        end
        idle_on = 1'b1;
    endtask

    // ---------------------------------------------------------------------------
    // Result side: random back-pressure
    // ---------------------------------------------------------------------------
    initial begin
        int stall;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            stall = idle_gap();
            if (stall == 0) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
                m_ready <= 1'b1;
            end
        end
    end

    // Each status item against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            status_seen++;
            if (expected_status_q.size() == 0) begin
                report_mismatch("status with nothing expected", int'(m_data), 0);
            end else begin
                want = expected_status_q.pop_front();
                if (m_data.drive_low !== want.drive_low) begin
                    report_mismatch("drive_low", int'(m_data.drive_low),
                                    int'(want.drive_low));
                end
                if (m_data.busy_res !== want.busy_res) begin
                    report_mismatch("busy_res", int'(m_data.busy_res), int'(want.busy_res));
                end
                if (m_data.done_res !== want.done_res) begin
                    report_mismatch("done_res", int'(m_data.done_res), int'(want.done_res));
                end
                if (m_data.presence !== want.presence) begin
                    report_mismatch("presence", int'(m_data.presence), int'(want.presence));
                end
                if (m_data.read_byte !== want.read_byte) begin
                    report_mismatch("read_byte", int'(m_data.read_byte),
                                    int'(want.read_byte));
                end
                if (m_data.rejected !== want.rejected) begin
                    report_mismatch("rejected", int'(m_data.rejected), int'(want.rejected));
                end
            end
        end
    end

    // Watchdog: any handshake or register write counts as progress.
    always @(posedge aclk) begin
        if (!aresetn || cfg_we || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout: no handshake for %0d cycles, %0d status items pending",
                     STALL_LIMIT, expected_status_q.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------------
    initial begin
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        aresetn   <= 1'b0;
        idle_on   = 1'b1;

        // model matches the block's reset state
        timing_us[owbm_pkg::CFG_RESET_LOW]     = owbm_pkg::RST_RESET_LOW;
        timing_us[owbm_pkg::CFG_PRESENCE_WAIT] = owbm_pkg::RST_PRESENCE_WAIT;
        timing_us[owbm_pkg::CFG_RESET_TAIL]    = owbm_pkg::RST_RESET_TAIL;
        timing_us[owbm_pkg::CFG_WRITE_LOW]     = owbm_pkg::RST_WRITE_LOW;
        timing_us[owbm_pkg::CFG_WRITE_HOLD]    = owbm_pkg::RST_WRITE_HOLD;
        timing_us[owbm_pkg::CFG_WRITE_RECOVER] = owbm_pkg::RST_WRITE_RECOVER;
        timing_us[owbm_pkg::CFG_READ_LOW]      = owbm_pkg::RST_READ_LOW;
        timing_us[owbm_pkg::CFG_READ_SAMPLE]   = owbm_pkg::RST_READ_SAMPLE;
        bus_phase   = PH_IDLE;
        slot_timer  = '0;
        bit_pos     = '0;
        shift_reg   = '0;
        pull_low    = 1'b0;
        device_seen = 1'b0;
        last_read   = '0;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_default_timing();
        test_min_timing();
        test_zero_timing();
        test_busy_reject();
        test_random();
        settle();

        if (expected_status_q.size() != 0) begin
            report_mismatch("status items never returned", 0, expected_status_q.size());
        end
        $display("Run: %0d items (%0d during commands), %0d status items checked",
                 items_sent, work_items, status_seen);
        $display("Commands: %0d completed, %0d refused while busy, %0d mismatches",
                 cmds_done, cmds_rejected, err_count);
        if (err_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
